[rtl/two_way_sorted_merge_unit_macros.svh]
// Assertion macros used by the merge unit RTL.
`ifndef TWO_WAY_SORTED_MERGE_UNIT_MACROS_SVH
`define TWO_WAY_SORTED_MERGE_UNIT_MACROS_SVH

// Same-cycle implication, checked on clk, off during reset.
`define TWSM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on clk, off during reset.
`define TWSM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/twsm_pkg.sv]
// Shared constants and types of the two-way sorted merge unit.
`default_nettype none

package twsm_pkg;

	localparam int SEQ_DEPTH = 32;
	localparam int IDX_W = (SEQ_DEPTH > 1) ? $clog2(SEQ_DEPTH) : 1;
	localparam int CNT_W = $clog2(SEQ_DEPTH + 1);
	localparam int DATA_W = 32;

	localparam logic [1:0] KIND_LOAD_FIRST = 2'd0;
	localparam logic [1:0] KIND_LOAD_SECOND = 2'd1;
	localparam logic [1:0] KIND_MERGE = 2'd2;

	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [IDX_W-1:0] idx_t;

endpackage

`default_nettype wire

[rtl/twsm_ram.sv]
// Simple dual-port synchronous RAM, one write and one registered read port.
`default_nettype none

module twsm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [ADDR_W-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

[rtl/two_way_sorted_merge_unit.sv]
// A load word is taken while the unit is idle; a merge word moves the unit to its merge state,
// which then puts one result per cycle in the output register while the output is not stalled.
// Throughput: one load per cycle; a merge of stored elements holds the input off until its
// last result is registered, paced by downstream stall and the one read port of each RAM.
// Reset clears both counts and the output valid; the stores stay undefined and are
// never read before being written, so no clearing pass runs.
`default_nettype none

module two_way_sorted_merge_unit (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [1:0] kind,
	input wire logic signed [31:0] value,
	output logic out_valid,
	input wire logic out_stall,
	output logic signed [31:0] merged_value,
	output logic last_out
);

	`include "two_way_sorted_merge_unit_macros.svh"

	localparam int SUM_W = twsm_pkg::CNT_W + 1;

	typedef enum logic {ST_IDLE, ST_MERGE} state_t;

	state_t state_q;
	twsm_pkg::cnt_t first_count_q, second_count_q;
	twsm_pkg::cnt_t a_q, b_q, a_d, b_d;
	logic out_valid_q;
	twsm_pkg::data_t merged_q;
	logic last_q;

	twsm_pkg::data_t rd_a, rd_b;
	logic in_acc, emit, a_left, b_left, take_a, is_last;
	logic we_a, we_b;
	logic [SUM_W-1:0] pos_sum, total;

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc = in_valid && !in_stall;

	assign we_a = in_acc && (kind == twsm_pkg::KIND_LOAD_FIRST) &&
		(first_count_q < twsm_pkg::CNT_W'(twsm_pkg::SEQ_DEPTH));
	assign we_b = in_acc && (kind == twsm_pkg::KIND_LOAD_SECOND) &&
		(second_count_q < twsm_pkg::CNT_W'(twsm_pkg::SEQ_DEPTH));

	always_comb begin
		emit = (state_q == ST_MERGE) && (!out_valid_q || !out_stall);
		a_left = a_q < first_count_q;
		b_left = b_q < second_count_q;
		// on equal heads the second sequence wins
		take_a = a_left && (!b_left || (rd_a < rd_b));
		pos_sum = {1'b0, a_q} + {1'b0, b_q} + SUM_W'(1);
		total = {1'b0, first_count_q} + {1'b0, second_count_q};
		is_last = (pos_sum == total);
		a_d = a_q;
		b_d = b_q;
		if (emit) begin
			if (is_last) begin
				a_d = '0;
				b_d = '0;
			end else if (take_a) begin
				a_d = a_q + twsm_pkg::CNT_W'(1);
			end else begin
				b_d = b_q + twsm_pkg::CNT_W'(1);
			end
		end
	end

	// read address follows the next head so the registered read data matches the head register
	twsm_ram #(
		.WIDTH(twsm_pkg::DATA_W),
		.DEPTH(twsm_pkg::SEQ_DEPTH)
	) u_ram_first (
		.clk(clk),
		.we(we_a),
		.waddr(first_count_q[twsm_pkg::IDX_W-1:0]),
		.wdata(value),
		.raddr(a_d[twsm_pkg::IDX_W-1:0]),
		.rdata(rd_a)
	);

	twsm_ram #(
		.WIDTH(twsm_pkg::DATA_W),
		.DEPTH(twsm_pkg::SEQ_DEPTH)
	) u_ram_second (
		.clk(clk),
		.we(we_b),
		.waddr(second_count_q[twsm_pkg::IDX_W-1:0]),
		.wdata(value),
		.raddr(b_d[twsm_pkg::IDX_W-1:0]),
		.rdata(rd_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			first_count_q <= '0;
			second_count_q <= '0;
			a_q <= '0;
			b_q <= '0;
			out_valid_q <= 1'b0;
			merged_q <= '0;
			last_q <= 1'b0;
		end else begin
			a_q <= a_d;
			b_q <= b_d;
			if (out_valid_q && !out_stall && !emit) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						case (kind)
							twsm_pkg::KIND_LOAD_FIRST: begin
								if (we_a) begin
									first_count_q <= first_count_q + twsm_pkg::CNT_W'(1);
								end
							end
							twsm_pkg::KIND_LOAD_SECOND: begin
								if (we_b) begin
									second_count_q <= second_count_q + twsm_pkg::CNT_W'(1);
								end
							end
							twsm_pkg::KIND_MERGE: begin
								if (total != '0) begin
									state_q <= ST_MERGE;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_MERGE: begin
					if (emit) begin
						out_valid_q <= 1'b1;
						merged_q <= take_a ? rd_a : rd_b;
						last_q <= is_last;
						if (is_last) begin
							first_count_q <= '0;
							second_count_q <= '0;
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign merged_value = merged_q;
	assign last_out = last_q;

	`TWSM_ASSERT_NOW(a_ptr_in_range, state_q == ST_MERGE,
		(a_q <= first_count_q) && (b_q <= second_count_q), "merge head past count")
	`TWSM_ASSERT_NOW(take_a_valid, emit && take_a, a_q < first_count_q,
		"first sequence taken when used up")
	`TWSM_ASSERT_NOW(take_b_valid, emit && !take_a, b_q < second_count_q,
		"second sequence taken when used up")
	`TWSM_ASSERT_NEXT(last_clears, emit && is_last,
		(first_count_q == '0) && (second_count_q == '0) && (a_q == '0) && (b_q == '0) &&
		out_valid_q && last_q, "last word did not close the merge")

endmodule

`default_nettype wire

[tb/sv/two_way_sorted_merge_unit_tb.sv]
// Self-checking testbench of the two-way sorted merge unit: directed and random loads, merges and stalls.
module two_way_sorted_merge_unit_tb;

	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int WORD_TARGET = 460;
	localparam int CYCLE_LIMIT = 400000;
	localparam int TAIL_CYCLES = 16;

	typedef struct {
		twsm_pkg::data_t v;
		logic  last;
	} merged_word_t;

	typedef enum int {STALL_NONE, STALL_LIGHT, STALL_PERIODIC, STALL_HEAVY} stall_mode_t;

	class merge_scoreboard;
		twsm_pkg::data_t first_mem[twsm_pkg::SEQ_DEPTH];
		twsm_pkg::data_t second_mem[twsm_pkg::SEQ_DEPTH];
		int           first_cnt;
		int           second_cnt;
		merged_word_t merged_due[$];
		int           errors;
		int           words_checked;

		function new();
			first_cnt = 0;
			second_cnt = 0;
			errors = 0;
			words_checked = 0;
		endfunction

		function int pending();
			return merged_due.size();
		endfunction

		// Update the shadow stores and queue every word a merge will emit.
		function void note_word(logic [1:0] k, twsm_pkg::data_t v);
			int a;
			int b;
			int total;
			merged_word_t w;
			a = 0;
			b = 0;
			case (k)
			twsm_pkg::KIND_LOAD_FIRST: begin
				if (first_cnt < twsm_pkg::SEQ_DEPTH) begin
					first_mem[first_cnt] = v;
					first_cnt++;
				end
			end
			twsm_pkg::KIND_LOAD_SECOND: begin
				if (second_cnt < twsm_pkg::SEQ_DEPTH) begin
					second_mem[second_cnt] = v;
					second_cnt++;
				end
			end
			twsm_pkg::KIND_MERGE: begin
				total = first_cnt + second_cnt;
				for (int n = 0; n < total; n++) begin
					// ties go to the second sequence
					if (a < first_cnt && (b >= second_cnt || first_mem[a] < second_mem[b])) begin
						w.v = first_mem[a];
						a++;
					end else begin
						w.v = second_mem[b];
						b++;
					end
					w.last = (n == total - 1);
					merged_due.push_back(w);
				end
				first_cnt = 0;
				second_cnt = 0;
			end
			default: ;
			endcase
		endfunction

		task report(string msg);
			$display("mismatch: %s", msg);
			errors++;
		endtask

		task check_word(twsm_pkg::data_t v, logic last);
			merged_word_t w;
			if (merged_due.size() == 0) begin
				report($sformatf("unexpected word value=%0d last=%0b", v, last));
				return;
			end
			w = merged_due.pop_front();
			words_checked++;
			if (v !== w.v)
				report($sformatf("word %0d: merged_value %0d, want %0d", words_checked, v, w.v));
			if (last !== w.last)
				report($sformatf("word %0d: last_out %0b, want %0b", words_checked, last, w.last));
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  kind = KIND_UNUSED;
	twsm_pkg::data_t value = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	twsm_pkg::data_t merged_value;
	logic        last_out;

	merge_scoreboard sb;
	int          cycle_cnt = 0;
	int          burst_left = 0;
	int          counted = 0;
	int          loads_taken = 0;
	int          merges_taken = 0;
	int          noise_taken = 0;
	stall_mode_t stall_mode = STALL_NONE;

	two_way_sorted_merge_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.value(value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.merged_value(merged_value),
		.last_out(last_out)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Result side: check accepted words, then pick next stall level.
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
		if (arst_n && out_valid === 1'b1 && out_stall == 1'b0)
			sb.check_word(merged_value, last_out);
		if (cycle_cnt % 80 == 0)
			stall_mode = stall_mode_t'($urandom_range(0, 3));
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			case (stall_mode)
			STALL_NONE: out_stall <= 1'b0;
			STALL_LIGHT: out_stall <= ($urandom_range(0, 2) == 0);
			STALL_PERIODIC: out_stall <= ((cycle_cnt % 7) < 3);
			default: out_stall <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	task automatic send_word(input logic [1:0] k, input twsm_pkg::data_t v);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 12);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		kind <= k;
		value <= v;
		@(posedge clk);
		while (in_stall !== 1'b0) @(posedge clk);
		sb.note_word(k, v);
		case (k)
		twsm_pkg::KIND_LOAD_FIRST, twsm_pkg::KIND_LOAD_SECOND: loads_taken++;
		twsm_pkg::KIND_MERGE: merges_taken++;
		default: noise_taken++;
		endcase
	endtask

	// Hold the input off until every queued merge word has come out.
	task automatic drain_hold();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	function automatic int pick_value(int style, int base);
		if (style == 3 || style == 4)
			return base + $urandom_range(0, 15);
		return int'($urandom());
	endfunction

	task automatic merge_set(input int n_first, input int n_second);
		int first_vals[$];
		int second_vals[$];
		int style;
		int base;
		style = $urandom_range(0, 5);
		case ($urandom_range(0, 2))
		0: base = int'(32'h8000_0000);
		1: base = -8;
		default: base = 2147483647 - 15;
		endcase
		for (int i = 0; i < n_first; i++)
			first_vals.push_back(pick_value(style, base));
		for (int i = 0; i < n_second; i++)
			second_vals.push_back(pick_value(style, base));
		// style 5 leaves the values unsorted
		if (style != 5) begin
			first_vals.sort();
			second_vals.sort();
		end
		while (first_vals.size() + second_vals.size() > 0) begin
			if ($urandom_range(0, 9) == 0)
				send_word(KIND_UNUSED, $urandom());
			if (second_vals.size() == 0 || (first_vals.size() != 0 && $urandom_range(0, 1) == 1))
				send_word(twsm_pkg::KIND_LOAD_FIRST, first_vals.pop_front());
			else
				send_word(twsm_pkg::KIND_LOAD_SECOND, second_vals.pop_front());
		end
		send_word(twsm_pkg::KIND_MERGE, $urandom());
		counted += ((n_first < twsm_pkg::SEQ_DEPTH) ? n_first : twsm_pkg::SEQ_DEPTH)
			+ ((n_second < twsm_pkg::SEQ_DEPTH) ? n_second : twsm_pkg::SEQ_DEPTH) + 1;
	endtask

	function automatic int pick_size();
		int r;
		r = $urandom_range(0, 9);
		if (r < 6)
			return $urandom_range(0, 8);
		if (r < 9)
			return $urandom_range(0, twsm_pkg::SEQ_DEPTH);
		return $urandom_range(twsm_pkg::SEQ_DEPTH, twsm_pkg::SEQ_DEPTH + 4);
	endfunction

	initial begin
		sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty merge, ignored kind, extremes and ties, one-sided merges
		send_word(twsm_pkg::KIND_MERGE, '0);
		send_word(KIND_UNUSED, 32'hFFFF_FFFF);
		send_word(twsm_pkg::KIND_LOAD_FIRST, 32'h8000_0000);
		send_word(twsm_pkg::KIND_LOAD_FIRST, -1);
		send_word(twsm_pkg::KIND_LOAD_FIRST, 0);
		send_word(KIND_UNUSED, 0);
		send_word(twsm_pkg::KIND_LOAD_FIRST, 32'h7FFF_FFFF);
		send_word(twsm_pkg::KIND_LOAD_SECOND, 32'h8000_0000);
		send_word(twsm_pkg::KIND_LOAD_SECOND, 0);
		send_word(twsm_pkg::KIND_LOAD_SECOND, 1);
		send_word(twsm_pkg::KIND_LOAD_SECOND, 32'h7FFF_FFFF);
		send_word(twsm_pkg::KIND_MERGE, 32'h7FFF_FFFF);
		drain_hold();
		send_word(twsm_pkg::KIND_LOAD_FIRST, 5);
		send_word(twsm_pkg::KIND_LOAD_FIRST, 3);
		send_word(twsm_pkg::KIND_MERGE, 32'h8000_0000);
		send_word(twsm_pkg::KIND_LOAD_SECOND, 32'h5555_5555);
		send_word(twsm_pkg::KIND_LOAD_SECOND, 32'hAAAA_AAAA);
		send_word(twsm_pkg::KIND_MERGE, 32'hFFFF_FFFF);
		drain_hold();

		// both stores overfilled: longest merge
		merge_set(twsm_pkg::SEQ_DEPTH + 2, twsm_pkg::SEQ_DEPTH + 1);
		drain_hold();
		while (counted < WORD_TARGET) begin
			merge_set(pick_size(), pick_size());
			if ($urandom_range(0, 3) == 0)
				drain_hold();
		end

		drain_hold();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("covered %0d load words, %0d merges and %0d ignored-kind words",
			loads_taken, merges_taken, noise_taken);
		$display("checked %0d merged words in %0d cycles", sb.words_checked, cycle_cnt);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

[two_way_sorted_merge_unit.f]
+incdir+rtl
rtl/twsm_pkg.sv
rtl/twsm_ram.sv
rtl/two_way_sorted_merge_unit.sv
tb/sv/two_way_sorted_merge_unit_tb.sv
